@@ design/enth_pkg.sv @@
package enth_pkg;

	// fixed point format of the datapath
	localparam int FRACTION_BITS = 24;

	typedef logic signed [63:0] fix_t;

	// correlation constants, rounded to nearest in the fixed point format
	localparam fix_t C_H1 = 64'sd27819979571;
	localparam fix_t C_H2 = 64'sd7112701;
	localparam fix_t C_H3 = 64'sd2491;
	localparam fix_t C_C1 = 64'sd14225401;
	localparam fix_t C_C2 = 64'sd7473;
	localparam fix_t C_TC = 64'sd42005115699;
	localparam fix_t C_FF = 64'sd4619103109;
	localparam fix_t C_GH = 64'sd4291444081;
	localparam fix_t C_H0 = 64'sd365770 <<< FRACTION_BITS;
	localparam fix_t C_RC = 64'sd2992600 <<< FRACTION_BITS;
	localparam fix_t T_MIN = 64'sd1 <<< FRACTION_BITS;
	localparam fix_t T_MAX = 64'sd4095 <<< FRACTION_BITS;
	localparam logic [63:0] PROD_LIM = (64'd1 << 62) - 64'd1;
	localparam fix_t OUT_LIM = (64'sd1 <<< 35) - 64'sd1;
	localparam logic [3:0] MAX_ITER_RESET = 4'd10;

	// saturation exponents of the quotient integer parts
	localparam logic [4:0] K_STEP = 5'd13;
	localparam logic [4:0] K_RECIP = 5'd23;
	localparam logic [4:0] K_ROOT = 5'd24;
	localparam logic [4:0] K_UNIT = 5'd0;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_ACC,
		A_MFIN,
		A_DIV,
		A_SQRT,
		A_DONE
	} alu_st_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_GUESS,
		S_E1,
		S_E2,
		S_E3,
		S_E4,
		S_C1,
		S_C2,
		S_C3,
		S_C4,
		S_NEWTON,
		S_TEST,
		S_FIN,
		S_X,
		S_SQ,
		S_G,
		S_D,
		S_DRHO,
		S_OUT
	} seq_st_t;

	// request to the shared arithmetic unit
	typedef struct packed {
		logic    start;
		alu_op_t op;
		fix_t    a;
		fix_t    b;
		logic [4:0] k;
		logic    frac40;
	} alu_req_t;

	function automatic logic [63:0] mag(input fix_t v);
		return v[63] ? (64'd0 - 64'(v)) : 64'(v);
	endfunction

endpackage

@@ design/enth_if.sv @@
interface enth_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] max_iterations;
	modport source(output valid, max_iterations, input ready);
	modport sink(input valid, max_iterations, output ready);
endinterface

interface enth_in_if;
	logic               valid;
	logic               ready;
	logic signed [22:0] enthalpy;
	modport source(output valid, enthalpy, input ready);
	modport sink(input valid, enthalpy, output ready);
endinterface

interface enth_out_if;
	logic               valid;
	logic               ready;
	logic [27:0]        temperature_q16;
	logic signed [35:0] drho_dh_scaled;
	logic               converged;
	logic [3:0]         iterations_used;
	logic               beyond_critical;
	modport source(output valid, temperature_q16, drho_dh_scaled, converged,
		iterations_used, beyond_critical, input ready);
	modport sink(input valid, temperature_q16, drho_dh_scaled, converged,
		iterations_used, beyond_critical, output ready);
endinterface

@@ design/enth_alu.sv @@
module enth_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  enth_pkg::alu_req_t req,
	output logic              done,
	output enth_pkg::fix_t    result
);

	enth_pkg::alu_st_t st_q, st_d;

	logic [63:0]  ua_q, ub_q, rem_q, sh_q, quot_q, prod_q;
	logic [127:0] acc_q;
	logic [1:0]   idx_q;
	logic [6:0]   cnt_q;
	logic         neg_q;
	enth_pkg::fix_t res_q;

	// operand preparation at start
	logic [63:0] ua, ub, hi, cap, sh_init;
	logic [6:0]  nbits;
	logic        neg, div_ovf;

	always_comb begin
		ua = enth_pkg::mag(req.a);
		ub = enth_pkg::mag(req.b);
		neg = req.a[63] ^ req.b[63];
		nbits = 7'(req.k) + (req.frac40 ? 7'd40 : 7'd24);
		cap = (64'd1 << nbits) - 64'd1;
		hi = ua >> req.k;
		div_ovf = (hi >= ub);
		sh_init = ua << (7'd64 - 7'(req.k));
	end

	// multiply partial product and accumulate
	logic [31:0]  a_half, b_half;
	logic [1:0]   half_sum;
	logic [127:0] prod_sh, scaled;
	logic [63:0]  mul_mag;

	always_comb begin
		a_half = idx_q[1] ? ua_q[63:32] : ua_q[31:0];
		b_half = idx_q[0] ? ub_q[63:32] : ub_q[31:0];
		half_sum = {1'b0, idx_q[1]} + {1'b0, idx_q[0]};
		prod_sh = {64'd0, prod_q} << ({5'd0, half_sum} << 5);
		scaled = acc_q >> enth_pkg::FRACTION_BITS;
		mul_mag = (scaled > {64'd0, enth_pkg::PROD_LIM}) ? enth_pkg::PROD_LIM : scaled[63:0];
	end

	// restoring division step
	logic [64:0] trial;
	logic        qbit;
	logic [63:0] quot_nx;

	always_comb begin
		trial = {rem_q, sh_q[63]};
		qbit = (trial >= {1'b0, ub_q});
		quot_nx = {quot_q[62:0], qbit};
	end

	// square root step
	logic [63:0] sq_sum, sq_res_nx;
	logic        sq_take;

	always_comb begin
		sq_sum = quot_q + sh_q;
		sq_take = (rem_q >= sq_sum);
		sq_res_nx = sq_take ? ((quot_q >> 1) + sh_q) : (quot_q >> 1);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= enth_pkg::A_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			enth_pkg::A_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						enth_pkg::ALU_MUL:  st_d = enth_pkg::A_MUL;
						enth_pkg::ALU_DIV:  st_d = (ua == 64'd0 || div_ovf) ?
							enth_pkg::A_DONE : enth_pkg::A_DIV;
						enth_pkg::ALU_SQRT: st_d = enth_pkg::A_SQRT;
						default:            st_d = enth_pkg::A_DONE;
					endcase
				end
			end
			enth_pkg::A_MUL:  st_d = enth_pkg::A_ACC;
			enth_pkg::A_ACC:  st_d = (idx_q == 2'd3) ? enth_pkg::A_MFIN : enth_pkg::A_MUL;
			enth_pkg::A_MFIN: st_d = enth_pkg::A_DONE;
			enth_pkg::A_DIV:  st_d = (cnt_q == 7'd1) ? enth_pkg::A_DONE : enth_pkg::A_DIV;
			enth_pkg::A_SQRT: st_d = (sh_q == 64'd1) ? enth_pkg::A_DONE : enth_pkg::A_SQRT;
			enth_pkg::A_DONE: st_d = enth_pkg::A_IDLE;
			default:          st_d = enth_pkg::A_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			enth_pkg::A_IDLE: begin
				if (req.start) begin
					ua_q <= ua;
					ub_q <= ub;
					neg_q <= neg;
					idx_q <= 2'd0;
					acc_q <= '0;
					quot_q <= '0;
					cnt_q <= nbits;
					if (req.op == enth_pkg::ALU_SQRT) begin
						rem_q <= ua;
						sh_q <= 64'd1 << 62;
					end else begin
						rem_q <= hi;
						sh_q <= sh_init;
					end
					if (ua == 64'd0) begin
						res_q <= '0;
					end else begin
						res_q <= neg ? -$signed(cap) : $signed(cap);
					end
				end
			end
			enth_pkg::A_MUL: begin
				prod_q <= 64'(a_half) * 64'(b_half);
			end
			enth_pkg::A_ACC: begin
				acc_q <= acc_q + prod_sh;
				idx_q <= idx_q + 2'd1;
			end
			enth_pkg::A_MFIN: begin
				res_q <= neg_q ? -$signed(mul_mag) : $signed(mul_mag);
			end
			enth_pkg::A_DIV: begin
				rem_q <= qbit ? 64'(trial - {1'b0, ub_q}) : trial[63:0];
				sh_q <= sh_q << 1;
				quot_q <= quot_nx;
				cnt_q <= cnt_q - 7'd1;
				res_q <= neg_q ? -$signed(quot_nx) : $signed(quot_nx);
			end
			enth_pkg::A_SQRT: begin
				if (sq_take) begin
					rem_q <= rem_q - sq_sum;
				end
				quot_q <= sq_res_nx;
				sh_q <= sh_q >> 2;
				res_q <= $signed(sq_res_nx);
			end
			default: begin
			end
		endcase
	end

	assign done = (st_q == enth_pkg::A_DONE);
	assign result = res_q;

endmodule

@@ design/enthalpy_to_temperature_newton_top.sv @@
// Liquid sodium enthalpy to temperature solver. A request carries a specific enthalpy
// in J/kg; the block starts from a linear guess, runs Newton-Raphson on the enthalpy
// correlation for up to max_iterations updates (reset value 10, a zero skips them),
// and returns the temperature in Q.16 kelvin, d(rho)/dh scaled by 2^40, a converged
// flag, the update count and a flag for temperatures at or above 2503.7 K (derivative
// then reads zero). The products, quotients and square roots of the correlation go
// through one shared unit: a 32x32 multiplier used four times per product, a
// one-bit-per-cycle divider that skips its loop on a zero dividend or an overflow,
// and a square root that settles one result bit per cycle. A request runs through
// the guess, the Newton updates and the derivative tail in turn; the block takes no
// new request until its result has been taken.
module enthalpy_to_temperature_newton_top (
	input logic         clk,
	input logic         arst_n,
	enth_cfg_if.sink    cfg,
	enth_in_if.sink     item_in,
	enth_out_if.source  result_out
);

	enth_pkg::seq_st_t st_q, st_d;

	logic [3:0]  maxit_q;
	logic        wait_q;
	logic signed [22:0] h_q;
	enth_pkg::fix_t t_q, a_q, r_q, cp_q, t2_q;
	logic [63:0] ra_q;
	logic [3:0]  used_q;
	logic        conv_q, fin_q, beyond_q;
	logic signed [35:0] drho_q;

	enth_pkg::alu_req_t alu_req;
	logic               alu_done;
	enth_pkg::fix_t     alu_res;

	enth_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.done   (alu_done),
		.result (alu_res)
	);

	function automatic enth_pkg::fix_t clamp_t(input enth_pkg::fix_t v);
		if (v < enth_pkg::T_MIN) begin
			return enth_pkg::T_MIN;
		end else if (v > enth_pkg::T_MAX) begin
			return enth_pkg::T_MAX;
		end else begin
			return v;
		end
	endfunction

	// derived request values
	enth_pkg::fix_t hq, t_new, drho_full;
	logic [22:0] h_abs;
	logic [63:0] habs, ra_scaled;
	logic        pass, accept;

	always_comb begin
		hq = 64'(h_q) <<< enth_pkg::FRACTION_BITS;
		h_abs = h_q[22] ? (23'd0 - 23'(h_q)) : 23'(h_q);
		habs = 64'(h_abs) << enth_pkg::FRACTION_BITS;
		ra_scaled = 64'(ra_q[43:0]) * 64'd1000000;
		pass = (ra_q[63:44] == 20'd0) && (ra_scaled < habs);
		t_new = clamp_t(t_q - alu_res);
		if (alu_res > enth_pkg::OUT_LIM) begin
			drho_full = enth_pkg::OUT_LIM;
		end else if (alu_res < -enth_pkg::OUT_LIM) begin
			drho_full = -enth_pkg::OUT_LIM;
		end else begin
			drho_full = alu_res;
		end
		accept = item_in.valid && item_in.ready;
	end

	// operation issued in each step
	logic uses_alu;

	always_comb begin
		uses_alu = 1'b1;
		alu_req.op = enth_pkg::ALU_MUL;
		alu_req.a = t_q;
		alu_req.b = t_q;
		alu_req.k = enth_pkg::K_STEP;
		alu_req.frac40 = 1'b0;
		unique case (st_q)
			enth_pkg::S_GUESS: begin
				alu_req.op = enth_pkg::ALU_DIV;
				alu_req.a = (64'(h_q) + 64'sd365770) <<< enth_pkg::FRACTION_BITS;
				alu_req.b = enth_pkg::C_H1;
			end
			enth_pkg::S_E1: alu_req.a = enth_pkg::C_H3;
			enth_pkg::S_E2, enth_pkg::S_E3: alu_req.a = a_q;
			enth_pkg::S_E4: begin
				alu_req.op = enth_pkg::ALU_DIV;
				alu_req.a = enth_pkg::C_RC;
				alu_req.k = enth_pkg::K_RECIP;
			end
			enth_pkg::S_C1: begin
			end
			enth_pkg::S_C2: alu_req.a = enth_pkg::C_C1;
			enth_pkg::S_C3: begin
				alu_req.a = enth_pkg::C_C2;
				alu_req.b = t2_q;
			end
			enth_pkg::S_C4: begin
				alu_req.op = enth_pkg::ALU_DIV;
				alu_req.a = enth_pkg::C_RC;
				alu_req.b = t2_q;
				alu_req.k = enth_pkg::K_RECIP;
			end
			enth_pkg::S_NEWTON: begin
				alu_req.op = enth_pkg::ALU_DIV;
				alu_req.a = r_q;
				alu_req.b = cp_q;
			end
			enth_pkg::S_X: begin
				alu_req.op = enth_pkg::ALU_DIV;
				alu_req.a = enth_pkg::C_TC - t_q;
				alu_req.b = enth_pkg::C_TC;
				alu_req.k = enth_pkg::K_UNIT;
			end
			enth_pkg::S_SQ: begin
				alu_req.op = enth_pkg::ALU_SQRT;
				alu_req.a = t2_q <<< enth_pkg::FRACTION_BITS;
			end
			enth_pkg::S_G: begin
				alu_req.op = enth_pkg::ALU_DIV;
				alu_req.a = enth_pkg::C_GH;
				alu_req.b = t2_q;
				alu_req.k = enth_pkg::K_ROOT;
			end
			enth_pkg::S_D: begin
				alu_req.op = enth_pkg::ALU_DIV;
				alu_req.a = -a_q;
				alu_req.b = enth_pkg::C_TC;
				alu_req.k = enth_pkg::K_ROOT;
			end
			enth_pkg::S_DRHO: begin
				alu_req.op = enth_pkg::ALU_DIV;
				alu_req.a = r_q;
				alu_req.b = cp_q;
				alu_req.k = enth_pkg::K_UNIT;
				alu_req.frac40 = 1'b1;
			end
			default: uses_alu = 1'b0;
		endcase
		alu_req.start = uses_alu && !wait_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= enth_pkg::S_IDLE;
			wait_q <= 1'b0;
			maxit_q <= enth_pkg::MAX_ITER_RESET;
		end else begin
			st_q <= st_d;
			if (alu_req.start) begin
				wait_q <= 1'b1;
			end else if (alu_done) begin
				wait_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				maxit_q <= cfg.max_iterations;
			end
		end
	end

	// sequencer next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			enth_pkg::S_IDLE: if (item_in.valid) st_d = enth_pkg::S_GUESS;
			enth_pkg::S_GUESS: if (alu_done) st_d = (maxit_q != 4'd0) ?
				enth_pkg::S_E1 : enth_pkg::S_FIN;
			enth_pkg::S_E1: if (alu_done) st_d = enth_pkg::S_E2;
			enth_pkg::S_E2: if (alu_done) st_d = enth_pkg::S_E3;
			enth_pkg::S_E3: if (alu_done) st_d = enth_pkg::S_E4;
			enth_pkg::S_E4: if (alu_done) st_d = enth_pkg::S_C1;
			enth_pkg::S_C1: if (alu_done) st_d = enth_pkg::S_C2;
			enth_pkg::S_C2: if (alu_done) st_d = enth_pkg::S_C3;
			enth_pkg::S_C3: if (alu_done) st_d = enth_pkg::S_C4;
			enth_pkg::S_C4: if (alu_done) st_d = fin_q ? enth_pkg::S_DRHO : enth_pkg::S_NEWTON;
			enth_pkg::S_NEWTON: if (alu_done) st_d = enth_pkg::S_TEST;
			enth_pkg::S_TEST: begin
				if (pass || used_q >= maxit_q) begin
					st_d = enth_pkg::S_FIN;
				end else begin
					st_d = enth_pkg::S_E1;
				end
			end
			enth_pkg::S_FIN: st_d = (t_q >= enth_pkg::C_TC) ? enth_pkg::S_OUT : enth_pkg::S_X;
			enth_pkg::S_X: if (alu_done) st_d = enth_pkg::S_SQ;
			enth_pkg::S_SQ: if (alu_done) st_d = enth_pkg::S_G;
			enth_pkg::S_G: if (alu_done) st_d = enth_pkg::S_D;
			enth_pkg::S_D: if (alu_done) st_d = enth_pkg::S_C1;
			enth_pkg::S_DRHO: if (alu_done) st_d = enth_pkg::S_OUT;
			enth_pkg::S_OUT: if (result_out.ready) st_d = enth_pkg::S_IDLE;
			default: st_d = enth_pkg::S_IDLE;
		endcase
	end

	// datapath registers, loaded as each operation completes and in the idle, test and finish steps
	always_ff @(posedge clk) begin
		unique case (st_q)
			enth_pkg::S_IDLE: begin
				if (accept) begin
					h_q <= item_in.enthalpy;
					used_q <= 4'd0;
					conv_q <= 1'b0;
					fin_q <= 1'b0;
					drho_q <= '0;
				end
			end
			enth_pkg::S_GUESS: if (alu_done) t_q <= clamp_t(alu_res);
			enth_pkg::S_E1: if (alu_done) a_q <= alu_res - enth_pkg::C_H2;
			enth_pkg::S_E2: if (alu_done) a_q <= alu_res + enth_pkg::C_H1;
			enth_pkg::S_E3: if (alu_done) a_q <= alu_res - enth_pkg::C_H0;
			enth_pkg::S_E4: if (alu_done) r_q <= a_q + alu_res - hq;
			enth_pkg::S_C1: if (alu_done) t2_q <= alu_res;
			enth_pkg::S_C2: if (alu_done) a_q <= enth_pkg::C_H1 - alu_res;
			enth_pkg::S_C3: if (alu_done) a_q <= a_q + alu_res;
			enth_pkg::S_C4: if (alu_done) cp_q <= a_q - alu_res;
			enth_pkg::S_NEWTON: begin
				if (alu_done) begin
					t_q <= t_new;
					used_q <= used_q + 4'd1;
					ra_q <= enth_pkg::mag(r_q);
				end
			end
			enth_pkg::S_TEST: conv_q <= pass;
			enth_pkg::S_FIN: begin
				beyond_q <= (t_q >= enth_pkg::C_TC);
				fin_q <= 1'b1;
			end
			enth_pkg::S_X: if (alu_done) t2_q <= alu_res;
			enth_pkg::S_SQ: begin
				if (alu_done) begin
					t2_q <= (alu_res == 64'sd0) ? 64'sd1 : alu_res;
				end
			end
			enth_pkg::S_G: if (alu_done) a_q <= enth_pkg::C_FF + alu_res;
			enth_pkg::S_D: if (alu_done) r_q <= alu_res;
			enth_pkg::S_DRHO: if (alu_done) drho_q <= drho_full[35:0];
			default: begin
			end
		endcase
	end

	// handshakes and result fields
	assign cfg.ready = 1'b1;
	assign item_in.ready = (st_q == enth_pkg::S_IDLE);
	assign result_out.valid = (st_q == enth_pkg::S_OUT);
	assign result_out.temperature_q16 =
		t_q[enth_pkg::FRACTION_BITS + 11 : enth_pkg::FRACTION_BITS - 16];
	assign result_out.drho_dh_scaled = drho_q;
	assign result_out.converged = conv_q;
	assign result_out.iterations_used = used_q;
	assign result_out.beyond_critical = beyond_q;

endmodule
